// ----- sv/graph_distance_map_and_path_core_macros.svh -----
`ifndef GRAPH_DISTANCE_MAP_AND_PATH_CORE_MACROS_SVH
`define GRAPH_DISTANCE_MAP_AND_PATH_CORE_MACROS_SVH

// Concurrent check sampled on clk, disabled while reset is asserted.
`define GDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check sampled on clk that also holds during reset.
`define GDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/gdm_pkg.sv -----
`default_nettype none
package gdm_pkg;

  // Fixed geometry of the graph.
  localparam int unsigned MAX_NODES  = 64;
  localparam int unsigned MAX_DEGREE = 8;
  localparam int unsigned NODE_W     = 6;
  localparam int unsigned DEG_W      = 3;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned NT_ADDR_W  = NODE_W + DEG_W;
  localparam int unsigned QCNT_W     = 7;
  localparam int unsigned MAX_STEPS  = 64;
  localparam int unsigned STEP_W     = 7;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [2:0] {
    CMD_CLEAR         = 3'd0,
    CMD_SET_WEIGHT    = 3'd1,
    CMD_ADD_NEIGHBOUR = 3'd2,
    CMD_MAP           = 3'd3,
    CMD_PATH          = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RMW_RD, S_RMW_WR, S_MAP_INIT, S_POP, S_POP_RD, S_NODE_RD,
    S_NB, S_NB_RD, S_NB_CMP, S_PATH, S_PATH_RD, S_PB, S_PB_RD, S_PB_CMP,
    S_PSTEP, S_FIN, S_DONE
  } state_t;

  // One node record: weight and neighbour count.
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [CNT_W-1:0]    count;
  } node_rec_t;

  // Result word handed from the sequencer to the output register.
  typedef struct packed {
    logic              push;
    logic [NODE_W-1:0] step_node;
    logic [DIST_W-1:0] step_distance;
    logic              last;
    logic [1:0]        status;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/gdm_if.sv -----
`default_nettype none
interface gdm_in_if
  import gdm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [2:0]          cmd;
  logic [NODE_W-1:0]   node;
  logic [NODE_W-1:0]   other_node;
  logic [WEIGHT_W-1:0] weight;

  modport source (output valid, cmd, node, other_node, weight, input ready);
  modport sink (input valid, cmd, node, other_node, weight, output ready);
endinterface

interface gdm_out_if
  import gdm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] step_node;
  logic [DIST_W-1:0] step_distance;
  logic              last;
  logic [1:0]        status;

  modport source (output valid, step_node, step_distance, last, status, input ready);
  modport sink (input valid, step_node, step_distance, last, status, output ready);
endinterface
`default_nettype wire

// ----- sv/gdm_ram.sv -----
`default_nettype none
module gdm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/gdm_seq.sv -----
`default_nettype none
`include "graph_distance_map_and_path_core_macros.svh"
module gdm_seq
  import gdm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [2:0]              cmd,
  input  wire logic [NODE_W-1:0]       node,
  input  wire logic [NODE_W-1:0]       other_node,
  input  wire logic [WEIGHT_W-1:0]     weight,
  input  wire logic                    slot_free,
  output logic                         idle,
  output res_t                         res,
  // Node record memory.
  output logic                         nm_we,
  output logic [NODE_W-1:0]            nm_waddr,
  output node_rec_t                    nm_wdata,
  output logic [NODE_W-1:0]            nm_raddr,
  input  wire node_rec_t               nm_rdata,
  // Distance memory.
  output logic                         dm_we,
  output logic [NODE_W-1:0]            dm_waddr,
  output logic [DIST_W-1:0]            dm_wdata,
  output logic [NODE_W-1:0]            dm_raddr,
  input  wire logic [DIST_W-1:0]       dm_rdata,
  // Neighbour table memory.
  output logic                         nt_we,
  output logic [NT_ADDR_W-1:0]         nt_waddr,
  output logic [NODE_W-1:0]            nt_wdata,
  output logic [NT_ADDR_W-1:0]         nt_raddr,
  input  wire logic [NODE_W-1:0]       nt_rdata,
  // Work queue memory.
  output logic                         wq_we,
  output logic [NODE_W-1:0]            wq_waddr,
  output logic [NODE_W-1:0]            wq_wdata,
  output logic [NODE_W-1:0]            wq_raddr,
  input  wire logic [NODE_W-1:0]       wq_rdata
);

  state_t state_r, state_nxt;

  logic [2:0]          cmd_r, cmd_nxt;
  logic [NODE_W-1:0]   node_r, node_nxt;
  logic [NODE_W-1:0]   other_r, other_nxt;
  logic [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [NODE_W-1:0]   cur_r, cur_nxt;
  logic [NODE_W-1:0]   v_r, v_nxt;
  logic [NODE_W-1:0]   next_r, next_nxt;
  logic [DIST_W-1:0]   best_r, best_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [NODE_W-1:0]   head_r, head_nxt;
  logic [QCNT_W-1:0]   qcnt_r, qcnt_nxt;
  logic [STEP_W-1:0]   k_r, k_nxt;
  logic                found_r, found_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [NODE_W-1:0]   pend_node_r, pend_node_nxt;
  logic [DIST_W-1:0]   pend_dist_r, pend_dist_nxt;
  logic [MAX_NODES-1:0] nm_vld_r, nm_vld_nxt;
  logic [MAX_NODES-1:0] dm_vld_r, dm_vld_nxt;
  logic [MAX_NODES-1:0] qflag_r, qflag_nxt;
  logic                nm_vq_r, dm_vq_r;

  node_rec_t           rec;
  logic [DIST_W-1:0]   dist_rd;
  logic [DIST_W:0]     sum;

  // Memory read data with entries never written showing their reset value.
  always_comb begin
    rec     = nm_vq_r ? nm_rdata : '0;
    dist_rd = dm_vq_r ? dm_rdata : DIST_MAX;
    sum     = {1'b0, dist_rd} + {{(DIST_W + 1 - WEIGHT_W){1'b0}}, rec.weight};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      qcnt_r     <= '0;
      pend_vld_r <= 1'b0;
      nm_vld_r   <= '0;
      dm_vld_r   <= '0;
      qflag_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      qcnt_r     <= qcnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      nm_vld_r   <= nm_vld_nxt;
      dm_vld_r   <= dm_vld_nxt;
      qflag_r    <= qflag_nxt;
    end
  end

  // Working registers and the valid bit of each read in flight.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    node_r      <= node_nxt;
    other_r     <= other_nxt;
    weight_r    <= weight_nxt;
    status_r    <= status_nxt;
    cur_r       <= cur_nxt;
    v_r         <= v_nxt;
    next_r      <= next_nxt;
    best_r      <= best_nxt;
    cnt_r       <= cnt_nxt;
    n_r         <= n_nxt;
    head_r      <= head_nxt;
    k_r         <= k_nxt;
    found_r     <= found_nxt;
    pend_node_r <= pend_node_nxt;
    pend_dist_r <= pend_dist_nxt;
    nm_vq_r     <= nm_vld_r[nm_raddr];
    dm_vq_r     <= dm_vld_r[dm_raddr];
  end

  // Sequencer: next state, memory accesses and result pushes.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    node_nxt      = node_r;
    other_nxt     = other_r;
    weight_nxt    = weight_r;
    status_nxt    = status_r;
    cur_nxt       = cur_r;
    v_nxt         = v_r;
    next_nxt      = next_r;
    best_nxt      = best_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    head_nxt      = head_r;
    qcnt_nxt      = qcnt_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    pend_vld_nxt  = pend_vld_r;
    pend_node_nxt = pend_node_r;
    pend_dist_nxt = pend_dist_r;
    nm_vld_nxt    = nm_vld_r;
    dm_vld_nxt    = dm_vld_r;
    qflag_nxt     = qflag_r;
    idle          = 1'b0;
    res           = '0;
    nm_we = 1'b0; nm_waddr = node_r; nm_wdata = '0; nm_raddr = cur_r;
    dm_we = 1'b0; dm_waddr = v_r; dm_wdata = best_r; dm_raddr = cur_r;
    nt_we = 1'b0; nt_waddr = '0; nt_wdata = other_r;
    nt_raddr = {cur_r, n_r[DEG_W-1:0]};
    wq_we = 1'b0; wq_waddr = '0; wq_wdata = v_r; wq_raddr = head_r;

    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          cmd_nxt    = cmd;
          node_nxt   = node;
          other_nxt  = other_node;
          weight_nxt = weight;
          status_nxt = ST_OK;
          cur_nxt    = node;
          k_nxt      = '0;
          pend_vld_nxt = 1'b0;
          case (cmd)
            CMD_CLEAR: begin
              nm_vld_nxt = '0;
              dm_vld_nxt = '0;
              qflag_nxt  = '0;
              state_nxt  = S_DONE;
            end
            CMD_SET_WEIGHT, CMD_ADD_NEIGHBOUR: state_nxt = S_RMW_RD;
            CMD_MAP:  state_nxt = S_MAP_INIT;
            CMD_PATH: state_nxt = S_PATH;
            default:  state_nxt = S_DONE;
          endcase
        end
      end

      S_RMW_RD: begin
        nm_raddr  = node_r;
        state_nxt = S_RMW_WR;
      end

      // Update the node record, and append to the list where there is room.
      S_RMW_WR: begin
        nm_vld_nxt[node_r] = 1'b1;
        nm_we = 1'b1;
        if (cmd_r == CMD_SET_WEIGHT) begin
          nm_wdata = '{weight: weight_r, count: rec.count};
        end else if (rec.count >= CNT_W'(MAX_DEGREE)) begin
          nm_wdata   = rec;
          status_nxt = ST_FULL;
        end else begin
          nm_wdata = '{weight: rec.weight, count: rec.count + CNT_W'(1)};
          nt_we    = 1'b1;
          nt_waddr = {node_r, rec.count[DEG_W-1:0]};
        end
        state_nxt = S_DONE;
      end

      // Reset the map and seed the queue with the focus node.
      S_MAP_INIT: begin
        dm_vld_nxt         = '0;
        dm_vld_nxt[node_r] = 1'b1;
        qflag_nxt          = '0;
        qflag_nxt[node_r]  = 1'b1;
        dm_we    = 1'b1;
        dm_waddr = node_r;
        dm_wdata = '0;
        wq_we    = 1'b1;
        wq_waddr = '0;
        wq_wdata = node_r;
        head_nxt = '0;
        qcnt_nxt = QCNT_W'(1);
        state_nxt = S_POP;
      end

      S_POP: begin
        wq_raddr  = head_r;
        state_nxt = (qcnt_r == '0) ? S_DONE : S_POP_RD;
      end

      S_POP_RD: begin
        cur_nxt   = wq_rdata;
        head_nxt  = head_r + NODE_W'(1);
        qcnt_nxt  = qcnt_r - QCNT_W'(1);
        qflag_nxt[wq_rdata] = 1'b0;
        nm_raddr  = wq_rdata;
        dm_raddr  = wq_rdata;
        state_nxt = S_NODE_RD;
      end

      // Candidate distance saturates one below unreached.
      S_NODE_RD: begin
        best_nxt  = (sum >= {1'b0, DIST_MAX}) ? DIST_MAX - DIST_W'(1) : sum[DIST_W-1:0];
        cnt_nxt   = rec.count;
        n_nxt     = '0;
        state_nxt = S_NB;
      end

      S_NB: begin
        state_nxt = (n_r == cnt_r) ? S_POP : S_NB_RD;
      end

      S_NB_RD: begin
        v_nxt     = nt_rdata;
        dm_raddr  = nt_rdata;
        state_nxt = S_NB_CMP;
      end

      // Relax one edge and queue the neighbour if it is not queued yet.
      S_NB_CMP: begin
        if (dist_rd > best_r) begin
          dm_we = 1'b1;
          dm_vld_nxt[v_r] = 1'b1;
          if (!qflag_r[v_r]) begin
            qflag_nxt[v_r] = 1'b1;
            wq_we    = 1'b1;
            wq_waddr = head_r + qcnt_r[NODE_W-1:0];
            qcnt_nxt = qcnt_r + QCNT_W'(1);
          end
        end
        n_nxt     = n_r + CNT_W'(1);
        state_nxt = S_NB;
      end

      S_PATH: begin
        if (cur_r == other_r || k_r == STEP_W'(MAX_STEPS)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_PATH_RD;
        end
      end

      S_PATH_RD: begin
        best_nxt  = dist_rd;
        cnt_nxt   = rec.count;
        n_nxt     = '0;
        found_nxt = 1'b0;
        state_nxt = S_PB;
      end

      S_PB: begin
        state_nxt = (n_r == cnt_r) ? S_PSTEP : S_PB_RD;
      end

      S_PB_RD: begin
        v_nxt     = nt_rdata;
        dm_raddr  = nt_rdata;
        state_nxt = S_PB_CMP;
      end

      // Earliest neighbour with the strictly smallest distance wins.
      S_PB_CMP: begin
        if (dist_rd < best_r) begin
          best_nxt  = dist_rd;
          next_nxt  = v_r;
          found_nxt = 1'b1;
        end
        n_nxt     = n_r + CNT_W'(1);
        state_nxt = S_PB;
      end

      // A step is held back one turn so the final one can carry last.
      S_PSTEP: begin
        if (!found_r) begin
          state_nxt = S_FIN;
        end else if (!pend_vld_r || slot_free) begin
          if (pend_vld_r) begin
            res = '{push: 1'b1, step_node: pend_node_r, step_distance: pend_dist_r,
                    last: 1'b0, status: ST_OK};
          end
          pend_vld_nxt  = 1'b1;
          pend_node_nxt = next_r;
          pend_dist_nxt = best_r;
          cur_nxt       = next_r;
          k_nxt         = k_r + STEP_W'(1);
          state_nxt     = S_PATH;
        end
      end

      S_FIN: begin
        if (slot_free) begin
          if (pend_vld_r) begin
            res = '{push: 1'b1, step_node: pend_node_r, step_distance: pend_dist_r,
                    last: 1'b1, status: ST_OK};
          end else begin
            res = '{push: 1'b1, step_node: '0, step_distance: '0,
                    last: 1'b1, status: ST_EMPTY};
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          res = '{push: 1'b1, step_node: '0, step_distance: '0,
                  last: 1'b1, status: status_r};
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // The queue never holds more entries than there are nodes.
  `GDM_ASSERT(a_qcnt_bound, qcnt_r <= QCNT_W'(MAX_NODES), "work queue overfilled")
  // A result is only pushed into a free output slot.
  `GDM_ASSERT(a_push_free, res.push |-> slot_free, "result pushed into full slot")
  // The queue is drained whenever the sequencer waits for a command.
  `GDM_ASSERT(a_idle_empty, (state_r == S_IDLE) |-> (qcnt_r == '0), "queue left non-empty")
  // The final result of a command returns the sequencer to idle.
  `GDM_ASSERT(a_last_idle, (res.push && res.last) |=> (state_r == S_IDLE), "no idle after last")

endmodule
`default_nettype wire

// ----- sv/graph_distance_map_and_path_core.sv -----
// Graph distance map and path engine for 64 nodes of up to 8 ordered neighbours each.
// One command word goes in; each command gives one result word, a path command one word
// per step (at most 64), the final word marked by last. The graph, distances and work
// queue sit in synchronous memories with one write and one read port, each read registered,
// so timing is set by memory traffic. A result word that finds the output register still
// occupied waits until the receiver takes the previous one. A new command word is taken as
// soon as the previous one is finished, even while its last result word still waits in the
// output register.
`default_nettype none
module graph_distance_map_and_path_core
  import gdm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  gdm_in_if.sink     in_ch,
  gdm_out_if.source  out_ch
);

  res_t res;
  logic idle;
  logic slot_free;
  logic out_vld_r;
  logic [NODE_W-1:0] out_node_r;
  logic [DIST_W-1:0] out_dist_r;
  logic out_last_r;
  logic [1:0] out_status_r;

  logic nm_we, dm_we, nt_we, wq_we;
  logic [NODE_W-1:0] nm_waddr, nm_raddr, dm_waddr, dm_raddr;
  logic [NODE_W-1:0] wq_waddr, wq_raddr, wq_wdata, wq_rdata;
  logic [NT_ADDR_W-1:0] nt_waddr, nt_raddr;
  logic [NODE_W-1:0] nt_wdata, nt_rdata;
  logic [DIST_W-1:0] dm_wdata, dm_rdata;
  node_rec_t nm_wdata, nm_rdata;

  assign in_ch.ready = idle;
  assign slot_free   = !out_vld_r || out_ch.ready;

  gdm_seq u_seq (
    .clk, .rst_n,
    .start(in_ch.valid && idle), .cmd(in_ch.cmd), .node(in_ch.node),
    .other_node(in_ch.other_node), .weight(in_ch.weight),
    .slot_free, .idle, .res,
    .nm_we, .nm_waddr, .nm_wdata, .nm_raddr, .nm_rdata,
    .dm_we, .dm_waddr, .dm_wdata, .dm_raddr, .dm_rdata,
    .nt_we, .nt_waddr, .nt_wdata, .nt_raddr, .nt_rdata,
    .wq_we, .wq_waddr, .wq_wdata, .wq_raddr, .wq_rdata
  );

  gdm_ram #(.WIDTH($bits(node_rec_t)), .DEPTH(MAX_NODES)) u_node_mem (
    .clk, .we(nm_we), .waddr(nm_waddr), .wdata(nm_wdata), .raddr(nm_raddr),
    .rdata(nm_rdata)
  );

  gdm_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_mem (
    .clk, .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata), .raddr(dm_raddr),
    .rdata(dm_rdata)
  );

  gdm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES * MAX_DEGREE)) u_nbr_mem (
    .clk, .we(nt_we), .waddr(nt_waddr), .wdata(nt_wdata), .raddr(nt_raddr),
    .rdata(nt_rdata)
  );

  gdm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_mem (
    .clk, .we(wq_we), .waddr(wq_waddr), .wdata(wq_wdata), .raddr(wq_raddr),
    .rdata(wq_rdata)
  );

  // Output register for one result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res.push) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) begin
      out_node_r   <= res.step_node;
      out_dist_r   <= res.step_distance;
      out_last_r   <= res.last;
      out_status_r <= res.status;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.step_node     = out_node_r;
  assign out_ch.step_distance = out_dist_r;
  assign out_ch.last          = out_last_r;
  assign out_ch.status        = out_status_r;

endmodule
`default_nettype wire

// ----- verif/gdm_tb_pkg.sv -----
package gdm_tb_pkg;
  import gdm_pkg::*;

  // One expected result word.
  typedef struct packed {
    logic [NODE_W-1:0] step_node;
    logic [DIST_W-1:0] step_distance;
    logic              last;
    logic [1:0]        status;
  } step_word_t;

  // Graph mirror used to predict the result words.
  class graph_mirror;
    logic [DIST_W-1:0]   dist_tab[MAX_NODES];
    logic [WEIGHT_W-1:0] wt[MAX_NODES];
    logic [NODE_W-1:0]   nbr[MAX_NODES][MAX_DEGREE];
    int unsigned         deg[MAX_NODES];

    function new();
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < MAX_NODES; i++) begin
        dist_tab[i] = DIST_MAX;
        wt[i] = '0;
        deg[i] = 0;
        for (int j = 0; j < MAX_DEGREE; j++) nbr[i][j] = '0;
      end
    endfunction

    // Queue relaxation from the focus node; the fixpoint does not depend on order.
    function void relax_from(int unsigned focus);
      int unsigned fifo[$];
      bit queued[MAX_NODES];
      int unsigned u, v;
      logic [DIST_W:0] sum;
      logic [DIST_W-1:0] cand;
      for (int i = 0; i < MAX_NODES; i++) begin
        dist_tab[i] = DIST_MAX;
        queued[i] = 0;
      end
      dist_tab[focus] = '0;
      fifo.insert(fifo.size(), focus);
      queued[focus] = 1;
      while (fifo.size() > 0) begin
        u = fifo.pop_front();
        queued[u] = 0;
        sum = {1'b0, dist_tab[u]} + {{(DIST_W + 1 - WEIGHT_W){1'b0}}, wt[u]};
        cand = (sum >= {1'b0, DIST_MAX}) ? DIST_MAX - DIST_W'(1) : sum[DIST_W-1:0];
        for (int n = 0; n < deg[u]; n++) begin
          v = nbr[u][n];
          if (dist_tab[v] > cand) begin
            dist_tab[v] = cand;
            if (!queued[v]) begin
              queued[v] = 1;
              fifo.insert(fifo.size(), v);
            end
          end
        end
      end
    endfunction

    // Predicts the words of one command and updates the mirror.
    function void predict(cmd_t cmd, int unsigned node, int unsigned other,
                          logic [WEIGHT_W-1:0] w, ref step_word_t words[$]);
      step_word_t sw;
      step_word_t step_w;
      int unsigned here, next;
      int unsigned steps;
      logic [DIST_W-1:0] best;
      bit found;
      sw = '{step_node: '0, step_distance: '0, last: 1'b1, status: ST_OK};
      steps = 0;
      case (cmd)
        CMD_CLEAR: wipe();
        CMD_SET_WEIGHT: wt[node] = w;
        CMD_ADD_NEIGHBOUR: begin
          if (deg[node] >= MAX_DEGREE) sw.status = ST_FULL;
          else begin
            nbr[node][deg[node]] = NODE_W'(other);
            deg[node]++;
          end
        end
        CMD_MAP: relax_from(node);
        CMD_PATH: begin
          here = node;
          while (here != other && steps < MAX_STEPS) begin
            best = dist_tab[here];
            found = 0;
            next = 0;
            for (int n = 0; n < deg[here]; n++)
              if (dist_tab[nbr[here][n]] < best) begin
                best = dist_tab[nbr[here][n]];
                next = nbr[here][n];
                found = 1;
              end
            if (!found) break;
            step_w = '{step_node: NODE_W'(next), step_distance: dist_tab[next],
                       last: 1'b0, status: ST_OK};
            words.insert(words.size(), step_w);
            steps++;
            here = next;
          end
          if (steps == 0) sw.status = ST_EMPTY;
          else begin
            words[words.size()-1].last = 1'b1;
            return;
          end
        end
        default: ;
      endcase
      words.insert(words.size(), sw);
    endfunction
  endclass
endpackage

// ----- verif/tb.sv -----
module tb;
  import gdm_pkg::*;
  import gdm_tb_pkg::*;

  // Command codes the block does not use; they must still give one plain result.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int IDLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 0;
  logic rst_n = 0;
  gdm_in_if  in_ch();
  gdm_out_if out_ch();

  graph_distance_map_and_path_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
                                        .out_ch(out_ch));

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  graph_mirror mirror = new();
  step_word_t pending_words[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int rx_wait = 0;

  // Sends one command word after a random gap and records its predicted results.
  task automatic send_word(logic [2:0] cmd, int unsigned node, int unsigned other,
                           logic [WEIGHT_W-1:0] w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.node <= NODE_W'(node);
    in_ch.other_node <= NODE_W'(other);
    in_ch.weight <= w;
    do @(posedge clk); while (!in_ch.ready);
    mirror.predict(cmd_t'(cmd), node, other, w, pending_words);
    words_sent++;
  endtask

  // Stops offering words and waits until every predicted result has arrived.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk);
  endtask

  // Receiver: a random wait before each word, or a long hold-off when one is requested.
  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_reqs;
      hold_off <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      draw = $urandom_range(0, 10);
      rx_wait <= draw;
      out_ch.ready <= (draw == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ch.ready <= (rx_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Checks each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    step_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word node=%0d dist=%0d", out_ch.step_node,
               out_ch.step_distance);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        words_checked++;
        if (out_ch.step_node !== exp_w.step_node) begin
          $error("step_node expected %0d got %0d", exp_w.step_node, out_ch.step_node);
          errors++;
        end
        if (out_ch.step_distance !== exp_w.step_distance) begin
          $error("step_distance expected %0d got %0d", exp_w.step_distance,
                 out_ch.step_distance);
          errors++;
        end
        if (out_ch.last !== exp_w.last) begin
          $error("last expected %0d got %0d", exp_w.last, out_ch.last);
          errors++;
        end
        if (out_ch.status !== exp_w.status) begin
          $error("status expected %0d got %0d", exp_w.status, out_ch.status);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Builds a random graph with random weights.
  task automatic build_graph(int unsigned nodes, int unsigned edges);
    send_word(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
              WEIGHT_W'($urandom));
    for (int i = 0; i < nodes; i++)
      send_word(CMD_SET_WEIGHT, i, $urandom_range(0, 63),
                WEIGHT_W'(($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 40)));
    for (int i = 0; i < edges; i++)
      send_word(CMD_ADD_NEIGHBOUR, $urandom_range(0, nodes - 1),
                $urandom_range(0, 1) ? $urandom_range(0, nodes - 1) : $urandom_range(0, 63),
                WEIGHT_W'($urandom));
  endtask

  task automatic test_directed();
    send_word(CMD_PATH, 0, 0, 8'h00);
    send_word(CMD_MAP, 63, 0, 8'h00);
    send_word(CMD_PATH, 5, 63, 8'h00);
    send_word(CMD_SET_WEIGHT, 0, 0, 8'hff);
    send_word(CMD_SET_WEIGHT, 63, 63, 8'h00);
    for (int i = 0; i < 9; i++) send_word(CMD_ADD_NEIGHBOUR, 0, 63 - i, 8'h00);
    send_word(CMD_ADD_NEIGHBOUR, 63, 0, 8'hff);
    send_word(CMD_MAP, 0, 0, 8'h00);
    send_word(CMD_PATH, 63, 0, 8'h00);
    send_word(CMD_PATH, 62, 0, 8'h00);
    send_word(CMD_SPARE_LO, 63, 63, 8'hff);
    send_word(CMD_SPARE_HI, 0, 0, 8'h00);
    send_word(CMD_CLEAR, 0, 0, 8'h00);
    send_word(CMD_PATH, 0, 1, 8'h00);
  endtask

  // A chain linked both ways with heavy weights gives a 63-step downhill path.
  task automatic test_long_chain();
    send_word(CMD_CLEAR, 0, 0, 8'h00);
    for (int i = 0; i < 63; i++) begin
      send_word(CMD_SET_WEIGHT, i + 1, 0, 8'hff);
      send_word(CMD_ADD_NEIGHBOUR, i + 1, i, 8'h00);
      send_word(CMD_ADD_NEIGHBOUR, i, i + 1, 8'h00);
    end
    send_word(CMD_MAP, 63, 0, 8'h00);
    send_word(CMD_PATH, 0, 63, 8'h00);
    send_word(CMD_PATH, 0, 0, 8'h00);
    send_word(CMD_PATH, 62, 0, 8'h00);
  endtask

  task automatic test_random(int unsigned rounds);
    int unsigned n;
    for (int r = 0; r < rounds; r++) begin
      n = $urandom_range(2, 16);
      build_graph(n, $urandom_range(n, 3 * n));
      send_word(CMD_MAP, $urandom_range(0, n - 1), 0, WEIGHT_W'($urandom));
      for (int p = 0; p < 4; p++)
        send_word(($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'(CMD_PATH),
                  $urandom_range(0, n - 1), $urandom_range(0, n - 1), WEIGHT_W'($urandom));
    end
  endtask

  // The receiver stalls for a long stretch while paths keep coming.
  task automatic test_backpressure();
    hold_reqs++;
    for (int i = 0; i < 6; i++) send_word(CMD_PATH, 0, 63, 8'h00);
    wait_drained();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.cmd <= '0;
    in_ch.node <= '0;
    in_ch.other_node <= '0;
    in_ch.weight <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_long_chain();
    test_backpressure();
    test_random(5);
    wait_drained();
    repeat (50) @(posedge clk);
    $display("tb: %0d command words sent, %0d result words checked", words_sent,
             words_checked);
    $display("tb: covered all commands, full lists, long paths and output stalls");
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/gdm_pkg.sv
sv/gdm_if.sv
sv/gdm_ram.sv
sv/gdm_seq.sv
sv/graph_distance_map_and_path_core.sv
verif/gdm_tb_pkg.sv
verif/tb.sv
